[rtl/core/lav_pkg.sv]
//------------------------------------------------------------------------------
// lav_pkg
// Shared widths and pipeline constants for the look-at view matrix core.
//------------------------------------------------------------------------------
package lav_pkg;

	localparam int unsigned COORD_WIDTH = 32;
	localparam int unsigned AXIS_WIDTH  = 16;

	// isqrt result bits of one normalizer, one register stage per bit
	localparam int unsigned NORM_SQRT_STEPS = 32;

endpackage

[rtl/core/lav_norm.sv]
//------------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: block-scale to [2^29,2^30), square-sum,
// restoring isqrt one result bit per stage, restoring divide per stage.
//------------------------------------------------------------------------------
module lav_norm #(
	parameter int unsigned IN_WIDTH   = 64,
	parameter int unsigned AXIS_WIDTH = lav_pkg::AXIS_WIDTH
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [IN_WIDTH-1:0]   a_x,
	input  logic signed [IN_WIDTH-1:0]   a_y,
	input  logic signed [IN_WIDTH-1:0]   a_z,
	output logic signed [AXIS_WIDTH-1:0] q_x,
	output logic signed [AXIS_WIDTH-1:0] q_y,
	output logic signed [AXIS_WIDTH-1:0] q_z
);
	localparam int unsigned FRAC  = AXIS_WIDTH - 2;
	localparam int unsigned SQ    = lav_pkg::NORM_SQRT_STEPS; // isqrt result bits
	localparam int unsigned DQ    = FRAC + 2;      // quotient bits (<= 2^FRAC)
	localparam int unsigned NW    = 30 + FRAC + 1; // numerator width
	localparam int unsigned SHW   = $clog2(IN_WIDTH + 32);

	// stage 1: magnitudes, signs
	logic [IN_WIDTH-1:0] m_s1 [3];
	logic [2:0]          neg_s1;
	// stage 2: scaled magnitudes (< 2^30)
	logic [29:0]         v_s2 [3];
	logic [2:0]          neg_s2;
	logic                zero_s2;
	// stage 3: squares
	logic [59:0]         p_s3 [3];
	logic [29:0]         v_s3 [3];
	logic [2:0]          neg_s3;
	logic                zero_s3;
	// isqrt pipeline
	logic [63:0]         rem_r [SQ+1];
	logic [31:0]         res_r [SQ+1];
	logic [29:0]         v_r   [SQ+1][3];
	logic [2:0]          neg_r [SQ+1];
	logic                zero_r[SQ+1];
	// divide pipeline: one quotient bit per stage, three lanes
	logic [NW-1:0]       num_d [DQ+1][3];
	logic [DQ-1:0]       quo_d [DQ+1][3];
	logic [31:0]         den_d [DQ+1];
	logic [2:0]          neg_d [DQ+1];
	logic                zero_d[DQ+1];

	logic [IN_WIDTH-1:0] mmax;
	logic [SHW-1:0]      lead;
	logic [IN_WIDTH-1:0] m_c [3];

	always_comb begin
		mmax = m_s1[0];
		if (m_s1[1] > mmax) mmax = m_s1[1];
		if (m_s1[2] > mmax) mmax = m_s1[2];
		lead = '0;
		for (int i = 0; i < IN_WIDTH; i++)
			if (mmax[i]) lead = SHW'(i);
		for (int k = 0; k < 3; k++)
			m_c[k] = m_s1[k];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0] <= a_x[IN_WIDTH-1] ? IN_WIDTH'(-a_x) : a_x;
			m_s1[1] <= a_y[IN_WIDTH-1] ? IN_WIDTH'(-a_y) : a_y;
			m_s1[2] <= a_z[IN_WIDTH-1] ? IN_WIDTH'(-a_z) : a_z;
			neg_s1  <= {a_z[IN_WIDTH-1], a_y[IN_WIDTH-1], a_x[IN_WIDTH-1]};

			zero_s2 <= (mmax == '0);
			neg_s2  <= neg_s1;
			for (int k = 0; k < 3; k++) begin
				if (lead >= SHW'(29))
					v_s2[k] <= 30'(m_c[k] >> (lead - SHW'(29)));
				else
					v_s2[k] <= 30'(m_c[k] << (SHW'(29) - lead));
			end

			for (int k = 0; k < 3; k++) begin
				p_s3[k] <= 60'(v_s2[k]) * 60'(v_s2[k]);
				v_s3[k] <= v_s2[k];
			end
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;

			rem_r[0]  <= 64'(p_s3[0]) + 64'(p_s3[1]) + 64'(p_s3[2]);
			res_r[0]  <= '0;
			v_r[0]    <= v_s3;
			neg_r[0]  <= neg_s3;
			zero_r[0] <= zero_s3;

			for (int s = 0; s < SQ; s++) begin
				logic [63:0] trial;
				logic [63:0] bitv;
				bitv  = 64'd1 << (2 * (SQ - 1 - s));
				trial = (64'(res_r[s]) << (SQ - s)) | bitv;
				if (rem_r[s] >= trial) begin
					rem_r[s+1] <= rem_r[s] - trial;
					res_r[s+1] <= res_r[s] | (32'd1 << (SQ - 1 - s));
				end else begin
					rem_r[s+1] <= rem_r[s];
					res_r[s+1] <= res_r[s];
				end
				v_r[s+1]    <= v_r[s];
				neg_r[s+1]  <= neg_r[s];
				zero_r[s+1] <= zero_r[s];
			end

			den_d[0]  <= (res_r[SQ] == '0) ? 32'd1 : res_r[SQ];
			neg_d[0]  <= neg_r[SQ];
			zero_d[0] <= zero_r[SQ];
			for (int k = 0; k < 3; k++) begin
				num_d[0][k] <= (NW'(v_r[SQ][k]) << FRAC) + NW'(res_r[SQ] >> 1);
				quo_d[0][k] <= '0;
			end
			for (int s = 0; s < DQ; s++) begin
				for (int k = 0; k < 3; k++) begin
					if ((num_d[s][k] >> (DQ - 1 - s)) >= NW'(den_d[s])) begin
						num_d[s+1][k] <= num_d[s][k] - (NW'(den_d[s]) << (DQ - 1 - s));
						quo_d[s+1][k] <= quo_d[s][k] | (DQ'(1) << (DQ - 1 - s));
					end else begin
						num_d[s+1][k] <= num_d[s][k];
						quo_d[s+1][k] <= quo_d[s][k];
					end
				end
				den_d[s+1]  <= den_d[s];
				neg_d[s+1]  <= neg_d[s];
				zero_d[s+1] <= zero_d[s];
			end

			q_x <= zero_d[DQ] ? '0 : (neg_d[DQ][0] ? -AXIS_WIDTH'(quo_d[DQ][0])
				: AXIS_WIDTH'(quo_d[DQ][0]));
			q_y <= zero_d[DQ] ? '0 : (neg_d[DQ][1] ? -AXIS_WIDTH'(quo_d[DQ][1])
				: AXIS_WIDTH'(quo_d[DQ][1]));
			q_z <= zero_d[DQ] ? '0 : (neg_d[DQ][2] ? -AXIS_WIDTH'(quo_d[DQ][2])
				: AXIS_WIDTH'(quo_d[DQ][2]));
		end
	end
endmodule

[rtl/core/look_at_view_matrix_core.sv]
//------------------------------------------------------------------------------
// look_at_view_matrix_core
// Left-handed look-at view matrix in fixed point, fully pipelined.
//------------------------------------------------------------------------------
// Depth: three chained normalizers plus input, two cross, dot and output
// registers.
// Throughput: one transfer per cycle; the whole pipe advances when the output
// register is empty or being taken (a global enable), so stalls lose nothing.
// Reset: arst_n clears all valid bits; payload registers are not reset.
// The depth is set by the per-bit isqrt and divide stages in each normalizer.
module look_at_view_matrix_core #(
	parameter int unsigned COORD_WIDTH = lav_pkg::COORD_WIDTH,
	parameter int unsigned AXIS_WIDTH  = lav_pkg::AXIS_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// eye_x, eye_y, eye_z, look_x, look_y, look_z, up_x, up_y, up_z
	input  logic [9*COORD_WIDTH-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// right_xyz, upward_xyz, forward_xyz (AXIS_WIDTH each), shift_xyz (COORD_WIDTH)
	output logic [9*AXIS_WIDTH+3*COORD_WIDTH-1:0] m_tdata
);
	localparam int unsigned FRAC  = AXIS_WIDTH - 2;
	localparam int unsigned NLAT  = 3 + 1 + lav_pkg::NORM_SQRT_STEPS + 1 + (FRAC + 2) + 1;
	localparam int unsigned CW    = 2 * AXIS_WIDTH + 1;
	localparam int unsigned DW    = COORD_WIDTH + AXIS_WIDTH + 2;
	// stage map: 1 in, N norm(fwd,up), 1 cross, N norm(rt), 1 cross, N norm(upw),
	// 1 dot, 1 out
	localparam int unsigned LAT   = 3 * NLAT + 5;
	// translation clamp bounds
	localparam logic signed [DW-1:0] SAT_HI = DW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// input stage
	logic signed [COORD_WIDTH-1:0] eye_s1 [3];
	logic signed [COORD_WIDTH:0]   dir_s1 [3];
	logic signed [COORD_WIDTH-1:0] up_s1  [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				eye_s1[k] <= s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
				up_s1[k]  <= s_tdata[(6+k)*COORD_WIDTH +: COORD_WIDTH];
				dir_s1[k] <= (COORD_WIDTH+1)'($signed(s_tdata[(3+k)*COORD_WIDTH +: COORD_WIDTH]))
					- (COORD_WIDTH+1)'($signed(s_tdata[k*COORD_WIDTH +: COORD_WIDTH]));
			end
		end
	end

	logic signed [AXIS_WIDTH-1:0] fwd [3], nup [3], rt [3], upw [3];

	lav_norm #(.IN_WIDTH(COORD_WIDTH+1), .AXIS_WIDTH(AXIS_WIDTH)) u_nf (
		.clk, .en, .a_x(dir_s1[0]), .a_y(dir_s1[1]), .a_z(dir_s1[2]),
		.q_x(fwd[0]), .q_y(fwd[1]), .q_z(fwd[2]));
	lav_norm #(.IN_WIDTH(COORD_WIDTH+1), .AXIS_WIDTH(AXIS_WIDTH)) u_nu (
		.clk, .en, .a_x((COORD_WIDTH+1)'(up_s1[0])),
		.a_y((COORD_WIDTH+1)'(up_s1[1])), .a_z((COORD_WIDTH+1)'(up_s1[2])),
		.q_x(nup[0]), .q_y(nup[1]), .q_z(nup[2]));

	// delay lines for eye and forward
	logic signed [COORD_WIDTH-1:0] eye_d [3*NLAT+2][3];
	logic signed [AXIS_WIDTH-1:0]  fwd_d [2*NLAT+2][3];
	always_ff @(posedge clk) begin
		if (en) begin
			eye_d[0] <= eye_s1;
			for (int s = 1; s < 3*NLAT+2; s++) eye_d[s] <= eye_d[s-1];
			fwd_d[0] <= fwd;
			for (int s = 1; s < 2*NLAT+2; s++) fwd_d[s] <= fwd_d[s-1];
		end
	end

	// cross(nup, fwd)
	logic signed [CW-1:0] c1 [3], c2 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			c1[0] <= CW'(nup[1]*fwd[2]) - CW'(nup[2]*fwd[1]);
			c1[1] <= CW'(nup[2]*fwd[0]) - CW'(nup[0]*fwd[2]);
			c1[2] <= CW'(nup[0]*fwd[1]) - CW'(nup[1]*fwd[0]);
		end
	end
	lav_norm #(.IN_WIDTH(CW), .AXIS_WIDTH(AXIS_WIDTH)) u_nr (
		.clk, .en, .a_x(c1[0]), .a_y(c1[1]), .a_z(c1[2]),
		.q_x(rt[0]), .q_y(rt[1]), .q_z(rt[2]));

	// fwd aligned with rt: index NLAT (covers the cross register and the rt normalizer)
	logic signed [AXIS_WIDTH-1:0] rt_d [NLAT+1][3];
	always_ff @(posedge clk) begin
		if (en) begin
			rt_d[0] <= rt;
			for (int s = 1; s < NLAT+1; s++) rt_d[s] <= rt_d[s-1];
			c2[0] <= CW'(fwd_d[NLAT][1]*rt[2]) - CW'(fwd_d[NLAT][2]*rt[1]);
			c2[1] <= CW'(fwd_d[NLAT][2]*rt[0]) - CW'(fwd_d[NLAT][0]*rt[2]);
			c2[2] <= CW'(fwd_d[NLAT][0]*rt[1]) - CW'(fwd_d[NLAT][1]*rt[0]);
		end
	end
	lav_norm #(.IN_WIDTH(CW), .AXIS_WIDTH(AXIS_WIDTH)) u_nw (
		.clk, .en, .a_x(c2[0]), .a_y(c2[1]), .a_z(c2[2]),
		.q_x(upw[0]), .q_y(upw[1]), .q_z(upw[2]));

	// dots: each axis aligned with upw
	logic signed [AXIS_WIDTH-1:0] a_rt [3], a_fw [3];
	assign a_rt = rt_d[NLAT];
	assign a_fw = fwd_d[2*NLAT+1];
	logic signed [DW-1:0] d_s [3];
	logic signed [AXIS_WIDTH-1:0] ax_s [3][3];
	// eye aligned: eye_d[0] at stage2, upw valid at stage 3*NLAT+3
	logic signed [COORD_WIDTH-1:0] ey [3];
	assign ey = eye_d[3*NLAT+1];
	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= DW'(a_rt[0]*ey[0]) + DW'(a_rt[1]*ey[1]) + DW'(a_rt[2]*ey[2]);
			d_s[1] <= DW'(upw[0]*ey[0]) + DW'(upw[1]*ey[1]) + DW'(upw[2]*ey[2]);
			d_s[2] <= DW'(a_fw[0]*ey[0]) + DW'(a_fw[1]*ey[1]) + DW'(a_fw[2]*ey[2]);
			ax_s[0] <= a_rt;
			ax_s[1] <= upw;
			ax_s[2] <= a_fw;
		end
	end

	// round, negate, saturate
	logic signed [DW-1:0] t [3];
	logic signed [COORD_WIDTH-1:0] sh [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t[k] = -((d_s[k] + (DW'(1) <<< (FRAC-1))) >>> FRAC);
			if (t[k] > SAT_HI)
				sh[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
			else if (t[k] < SAT_LO)
				sh[k] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
			else
				sh[k] = COORD_WIDTH'(t[k]);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				m_tdata[k*AXIS_WIDTH +: AXIS_WIDTH]       <= ax_s[0][k];
				m_tdata[(3+k)*AXIS_WIDTH +: AXIS_WIDTH]   <= ax_s[1][k];
				m_tdata[(6+k)*AXIS_WIDTH +: AXIS_WIDTH]   <= ax_s[2][k];
				m_tdata[9*AXIS_WIDTH + k*COORD_WIDTH +: COORD_WIDTH] <= sh[k];
			end
		end
	end
endmodule
